// File: hw/rtl/hsl_to_rgb_converter_unit_defines.svh
// Assertion helpers for the HSL to RGB converter.
// Both forms assume a clock named clk and an active-low reset named rst_n in scope.
`ifndef HSL_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define H2R_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication.
`define H2R_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// File: hw/rtl/h2r_pkg.sv
`timescale 1ns / 1ps

package h2r_pkg;

    localparam int unsigned HUE_W       = 15;
    localparam int unsigned SAT_W       = 17;
    localparam int unsigned CH_W        = 8;
    localparam int unsigned HUE_LIMIT   = 23040;
    localparam int unsigned SECTOR      = 3840;
    localparam int unsigned Q16_ONE     = 65536;
    localparam int unsigned CQ_W        = 17;
    localparam int unsigned C32_W       = 34;
    localparam int unsigned F_W         = 12;
    localparam int unsigned P_W         = 35;
    localparam int unsigned VAL_W       = 46;
    localparam int unsigned ROUND_SHIFT = 40;
    localparam int unsigned PIPE_DEPTH  = 6;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

endpackage

// File: hw/rtl/h2r_chan_round.sv
`timescale 1ns / 1ps

module h2r_chan_round
    import h2r_pkg::*;
(
    input  logic [VAL_W-1:0] val,
    output logic [CH_W-1:0]  chan
);

    localparam int unsigned SUM_W = VAL_W + 5;
    localparam int unsigned Q_W   = SUM_W - ROUND_SHIFT;

    logic [SUM_W-1:0] sum;
    logic [Q_W-1:0]   quo;

    // scale by 17 and round half up at bit ROUND_SHIFT
    assign sum = (SUM_W'(val) << 4) + SUM_W'(val) + (SUM_W'(1) << (ROUND_SHIFT - 1));
    assign quo = sum[SUM_W-1:ROUND_SHIFT];

    always_comb
    begin
        if (quo > Q_W'((1 << CH_W) - 1))
        begin
            chan = '1;
        end
        else
        begin
            chan = quo[CH_W-1:0];
        end
    end

endmodule

// File: hw/rtl/hsl_to_rgb_converter_unit.sv
// HSL to RGB converter: takes one pixel per clock (start high while busy is low; busy
// never rises) and returns it as a one-cycle done strobe carrying red, green, blue and
// invalid. The pipeline has six register stages (range check and sector decode, chroma
// multiply, hue-weighted multiply, scale, channel select, round and clamp) and it
// sustains one pixel per clock. There is no back-pressure: the receiver must take every
// beat in the cycle done is high. Out-of-range hue, saturation or lightness gives
// invalid high and zero channels.
`timescale 1ns / 1ps
`include "hsl_to_rgb_converter_unit_defines.svh"

module hsl_to_rgb_converter_unit
    import h2r_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [HUE_W-1:0] hue,
    input  logic [SAT_W-1:0] saturation,
    input  logic [SAT_W-1:0] lightness,
    output logic             done,
    output logic [CH_W-1:0]  red,
    output logic [CH_W-1:0]  green,
    output logic [CH_W-1:0]  blue,
    output logic             invalid
);

    logic             in_bad;
    sector_t          s1_sec_next;
    logic [HUE_W-1:0] s1_base;
    logic [HUE_W-1:0] s1_off;
    logic [F_W-1:0]   s1_f_next;
    logic [SAT_W:0]   lit2;
    logic [SAT_W:0]   cq_wide;
    logic [CQ_W-1:0]  s1_cq_next;

    logic             s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic             s1_bad_reg, s2_bad_reg, s3_bad_reg, s4_bad_reg, s5_bad_reg;
    sector_t          s1_sec_reg, s2_sec_reg, s3_sec_reg, s4_sec_reg;
    logic [F_W-1:0]   s1_f_reg, s2_f_reg;
    logic [CQ_W-1:0]  s1_cq_reg;
    logic [SAT_W-1:0] s1_sat_reg;
    logic [SAT_W-1:0] s1_lit_reg, s2_lit_reg;
    logic [C32_W-1:0] s2_c32_reg;
    logic [P_W-1:0]   s3_p_reg, s3_q_reg;
    logic [VAL_W-1:0] s3_xr_reg, s4_xr_reg;
    logic [VAL_W-1:0] s4_mn_reg, s4_cm_reg;
    logic [VAL_W-1:0] s5_r_reg, s5_g_reg, s5_b_reg;

    logic [P_W-1:0]   lit_q17;
    logic [VAL_W-1:0] s5_xm;
    logic [VAL_W-1:0] s5_r_next, s5_g_next, s5_b_next;
    logic [CH_W-1:0]  rnd_r, rnd_g, rnd_b;

    logic             done_reg, invalid_reg;
    logic [CH_W-1:0]  red_reg, green_reg, blue_reg;

    assign busy = 1'b0;

    // stage 1: range check, sector decode, chroma factor
    assign in_bad = (hue >= HUE_W'(HUE_LIMIT)) || (saturation > SAT_W'(Q16_ONE))
                    || (lightness > SAT_W'(Q16_ONE));

    always_comb
    begin
        if (hue < HUE_W'(SECTOR))
        begin
            s1_sec_next = SEC_RY;
            s1_base     = '0;
        end
        else if (hue < HUE_W'(2 * SECTOR))
        begin
            s1_sec_next = SEC_YG;
            s1_base     = HUE_W'(SECTOR);
        end
        else if (hue < HUE_W'(3 * SECTOR))
        begin
            s1_sec_next = SEC_GC;
            s1_base     = HUE_W'(2 * SECTOR);
        end
        else if (hue < HUE_W'(4 * SECTOR))
        begin
            s1_sec_next = SEC_CB;
            s1_base     = HUE_W'(3 * SECTOR);
        end
        else if (hue < HUE_W'(5 * SECTOR))
        begin
            s1_sec_next = SEC_BM;
            s1_base     = HUE_W'(4 * SECTOR);
        end
        else
        begin
            s1_sec_next = SEC_MR;
            s1_base     = HUE_W'(5 * SECTOR);
        end
    end

    assign s1_off = hue - s1_base;

    always_comb
    begin
        if (s1_sec_next inside {SEC_YG, SEC_CB, SEC_MR})
        begin
            s1_f_next = F_W'(SECTOR) - s1_off[F_W-1:0];
        end
        else
        begin
            s1_f_next = s1_off[F_W-1:0];
        end
    end

    assign lit2    = {lightness, 1'b0};
    assign cq_wide = (lightness >= SAT_W'(Q16_ONE / 2)) ? ((SAT_W + 1)'(2 * Q16_ONE) - lit2)
                                                        : lit2;
    assign s1_cq_next = cq_wide[CQ_W-1:0];

    // stage 4 to 5: build X + m and map by sector
    assign s5_xm = s4_mn_reg + s4_xr_reg;

    always_comb
    begin
        unique case (s4_sec_reg)
            SEC_RY:
            begin
                s5_r_next = s4_cm_reg; s5_g_next = s5_xm;     s5_b_next = s4_mn_reg;
            end
            SEC_YG:
            begin
                s5_r_next = s5_xm;     s5_g_next = s4_cm_reg; s5_b_next = s4_mn_reg;
            end
            SEC_GC:
            begin
                s5_r_next = s4_mn_reg; s5_g_next = s4_cm_reg; s5_b_next = s5_xm;
            end
            SEC_CB:
            begin
                s5_r_next = s4_mn_reg; s5_g_next = s5_xm;     s5_b_next = s4_cm_reg;
            end
            SEC_BM:
            begin
                s5_r_next = s5_xm;     s5_g_next = s4_mn_reg; s5_b_next = s4_cm_reg;
            end
            SEC_MR:
            begin
                s5_r_next = s4_cm_reg; s5_g_next = s4_mn_reg; s5_b_next = s5_xm;
            end
            default:
            begin
                s5_r_next = s4_mn_reg; s5_g_next = s4_mn_reg; s5_b_next = s4_mn_reg;
            end
        endcase
    end

    assign lit_q17 = P_W'({s2_lit_reg, 17'd0});

    h2r_chan_round u_round_r (.val(s5_r_reg), .chan(rnd_r));
    h2r_chan_round u_round_g (.val(s5_g_reg), .chan(rnd_g));
    h2r_chan_round u_round_b (.val(s5_b_reg), .chan(rnd_b));

    // advance the valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            done_reg   <= s5_vld_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        s1_bad_reg <= in_bad;
        s1_sec_reg <= s1_sec_next;
        s1_f_reg   <= s1_f_next;
        s1_cq_reg  <= s1_cq_next;
        s1_sat_reg <= saturation;
        s1_lit_reg <= lightness;

        s2_bad_reg <= s1_bad_reg;
        s2_sec_reg <= s1_sec_reg;
        s2_f_reg   <= s1_f_reg;
        s2_lit_reg <= s1_lit_reg;
        s2_c32_reg <= C32_W'(s1_cq_reg) * C32_W'(s1_sat_reg);

        s3_bad_reg <= s2_bad_reg;
        s3_sec_reg <= s2_sec_reg;
        s3_p_reg   <= lit_q17 - P_W'(s2_c32_reg);
        s3_q_reg   <= lit_q17 + P_W'(s2_c32_reg);
        s3_xr_reg  <= VAL_W'(s2_c32_reg) * VAL_W'(s2_f_reg);

        s4_bad_reg <= s3_bad_reg;
        s4_sec_reg <= s3_sec_reg;
        s4_mn_reg  <= VAL_W'(s3_p_reg) * VAL_W'(SECTOR / 2);
        s4_cm_reg  <= VAL_W'(s3_q_reg) * VAL_W'(SECTOR / 2);
        s4_xr_reg  <= s3_xr_reg;

        s5_bad_reg <= s4_bad_reg;
        s5_r_reg   <= s5_r_next;
        s5_g_reg   <= s5_g_next;
        s5_b_reg   <= s5_b_next;

        // drop channels on an out-of-range beat
        invalid_reg <= s5_bad_reg;
        red_reg     <= s5_bad_reg ? '0 : rnd_r;
        green_reg   <= s5_bad_reg ? '0 : rnd_g;
        blue_reg    <= s5_bad_reg ? '0 : rnd_b;
    end

    assign done    = done_reg;
    assign invalid = invalid_reg;
    assign red     = red_reg;
    assign green   = green_reg;
    assign blue    = blue_reg;

    `H2R_ASSERT_IMPL(a_bad_zero, done && invalid, (red == '0 && green == '0 && blue == '0), "invalid beat with nonzero channel")
    `H2R_ASSERT_IMPL(a_latency, start && !busy, ##PIPE_DEPTH done, "accepted beat did not emerge on time")
    `H2R_ASSERT_IMPL(a_flag_track, done, invalid == $past(in_bad, PIPE_DEPTH), "invalid flag lost its beat")
    `H2R_ASSERT_NEXT(a_chroma_order, s3_vld_reg && !s3_bad_reg, s4_cm_reg >= s4_mn_reg, "chroma term below offset")

endmodule
